// File: rtl/gql_pkg.sv
// Shared types and constants for the grid Q-learning update core.
// No dependencies; imported by gql_move, gql_update and the top level.
`default_nettype none

package gql_pkg;

    localparam int Q_W        = 32;     // Q value width, signed fixed point
    localparam int COEF_W     = 16;     // alpha / gamma width, unsigned Q0.16
    localparam int COORD_W    = 6;      // port width of a cell coordinate
    localparam int RND_BITS   = 16;     // fraction bits of alpha and gamma
    localparam int ROUND_HALF = 1 << (RND_BITS - 1);

    localparam logic [COEF_W-1:0]  LEARN_RATE_RST = 16'd6554;
    localparam logic [COEF_W-1:0]  DISCOUNT_RST   = 16'd62259;
    localparam logic [COORD_W-1:0] GOAL_RST       = 6'd0;

    typedef logic signed [7:0] t_reward;

    localparam t_reward REW_STEP  = -8'sd1;
    localparam t_reward REW_BLOCK = -8'sd50;
    localparam t_reward REW_GOAL  = 8'sd100;

    typedef enum logic [1:0] {
        ACT_RIGHT,
        ACT_LEFT,
        ACT_DOWN,
        ACT_UP
    } t_action;

    typedef enum logic [1:0] {
        REG_LEARN_RATE,
        REG_DISCOUNT,
        REG_GOAL_X,
        REG_GOAL_Y
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD01,
        ST_RD23,
        ST_RDOLD,
        ST_GMUL,
        ST_DELTA,
        ST_AMUL,
        ST_DONE
    } t_state;

    // move decoder -> top
    typedef struct packed {
        logic    goal;
        t_reward reward;
    } t_move_flags;

    // sequencer -> update datapath
    typedef struct packed {
        logic load_old;
        logic load_gamma;
        logic load_delta;
        logic load_alpha;
    } t_upd_ctrl;

endpackage

`default_nettype wire

// File: rtl/gql_qmem.sv
// Q table storage: one write port, two read ports, registered read data.
// Standalone; no package needed.
`default_nettype none

module gql_qmem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [31:0]       i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [31:0]       o_rdata_a,
    output logic      [31:0]       o_rdata_b
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata_a;
    logic [31:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// File: rtl/gql_move.sv
// Move decoder: clamps the position, applies the action, picks the reward,
// flags the goal and forms the table cell indexes. Uses gql_pkg.
`default_nettype none

module gql_move import gql_pkg::*; #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64,
    parameter int CX_W   = 6,
    parameter int CY_W   = 6,
    parameter int CELL_W = 12
) (
    input  wire logic [COORD_W-1:0] i_pos_x,
    input  wire logic [COORD_W-1:0] i_pos_y,
    input  wire logic [1:0]         i_action,
    input  wire logic               i_target_blocked,
    input  wire logic [COORD_W-1:0] i_goal_x,
    input  wire logic [COORD_W-1:0] i_goal_y,
    output logic      [CX_W-1:0]    o_nx,
    output logic      [CY_W-1:0]    o_ny,
    output logic      [CELL_W-1:0]  o_cell_cur,
    output logic      [CELL_W-1:0]  o_cell_next,
    output t_move_flags             o_flags
);

    logic [CX_W-1:0] x_c;
    logic [CY_W-1:0] y_c;
    logic [CX_W-1:0] nx;
    logic [CY_W-1:0] ny;
    logic            blocked;

    // out-of-grid positions clamp to the last column / row
    assign x_c = (int'(i_pos_x) >= GRID_W) ? CX_W'(GRID_W - 1) : CX_W'(i_pos_x);
    assign y_c = (int'(i_pos_y) >= GRID_H) ? CY_W'(GRID_H - 1) : CY_W'(i_pos_y);

    always_comb begin
        nx      = x_c;
        ny      = y_c;
        blocked = i_target_blocked;
        unique case (t_action'(i_action))
            ACT_RIGHT: begin
                if (x_c == CX_W'(GRID_W - 1)) blocked = 1'b1;
                else nx = x_c + CX_W'(1);
            end
            ACT_LEFT: begin
                if (x_c == '0) blocked = 1'b1;
                else nx = x_c - CX_W'(1);
            end
            ACT_DOWN: begin
                if (y_c == CY_W'(GRID_H - 1)) blocked = 1'b1;
                else ny = y_c + CY_W'(1);
            end
            ACT_UP: begin
                if (y_c == '0) blocked = 1'b1;
                else ny = y_c - CY_W'(1);
            end
        endcase
        if (blocked) begin
            nx = x_c;
            ny = y_c;
        end
    end

    always_comb begin
        o_flags.goal = (nx == CX_W'(i_goal_x)) && (ny == CY_W'(i_goal_y));
        if (o_flags.goal)  o_flags.reward = REW_GOAL;
        else if (blocked)  o_flags.reward = REW_BLOCK;
        else               o_flags.reward = REW_STEP;
    end

    assign o_nx        = nx;
    assign o_ny        = ny;
    assign o_cell_cur  = CELL_W'(y_c) * CELL_W'(GRID_W) + CELL_W'(x_c);
    assign o_cell_next = CELL_W'(ny) * CELL_W'(GRID_W) + CELL_W'(nx);

endmodule

`default_nettype wire

// File: rtl/gql_update.sv
// Q update datapath: gamma*maxQ, TD error, alpha*delta, saturating add;
// greedy mode passes the old Q. Four registers driven by t_upd_ctrl. Uses gql_pkg.
`default_nettype none

module gql_update import gql_pkg::*; #(
    parameter int Q_FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire t_upd_ctrl              i_ctrl,
    input  wire logic [COEF_W-1:0]      i_learn_rate,
    input  wire logic [COEF_W-1:0]      i_discount,
    input  wire t_reward                i_reward,
    input  wire logic                   i_greedy,
    input  wire logic signed [Q_W-1:0]  i_best_q,
    input  wire logic signed [Q_W-1:0]  i_old_q,
    output logic      signed [Q_W-1:0]  o_new_q
);

    localparam int GP_W = COEF_W + 1 + Q_W;     // gamma * maxQ
    localparam int DW   = Q_W + 3;              // TD error
    localparam int AP_W = COEF_W + 1 + DW;      // alpha * delta
    localparam int G_W  = GP_W + 1 - RND_BITS;
    localparam int ST_W = AP_W + 1 - RND_BITS;
    localparam int SW   = ST_W + 1;

    logic signed [Q_W-1:0]  r_old_q;
    logic signed [GP_W-1:0] r_gprod;
    logic signed [DW-1:0]   r_delta;
    logic signed [AP_W-1:0] r_aprod;

    logic signed [GP_W:0]   g_sum;
    logic signed [G_W-1:0]  g;
    logic signed [DW-1:0]   r_fix;
    logic signed [DW-1:0]   n_delta;
    logic signed [AP_W:0]   a_sum;
    logic signed [ST_W-1:0] step;
    logic signed [SW-1:0]   q_sum;
    logic signed [Q_W-1:0]  q_sat;

    // round half up, then floor shift
    assign g_sum   = (GP_W + 1)'(r_gprod) + (GP_W + 1)'(ROUND_HALF);
    assign g       = $signed(g_sum[GP_W:RND_BITS]);
    assign r_fix   = DW'(i_reward) <<< Q_FRAC_BITS;
    assign n_delta = r_fix + DW'(g) - DW'(r_old_q);

    assign a_sum = (AP_W + 1)'(r_aprod) + (AP_W + 1)'(ROUND_HALF);
    assign step  = $signed(a_sum[AP_W:RND_BITS]);
    assign q_sum = SW'(r_old_q) + SW'(step);

    always_comb begin
        if ((&q_sum[SW-1:Q_W-1]) || !(|q_sum[SW-1:Q_W-1])) begin
            q_sat = q_sum[Q_W-1:0];
        end else if (q_sum[SW-1]) begin
            q_sat = {1'b1, {(Q_W - 1){1'b0}}};
        end else begin
            q_sat = {1'b0, {(Q_W - 1){1'b1}}};
        end
    end

    assign o_new_q = i_greedy ? r_old_q : q_sat;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_old) begin
            r_old_q <= i_old_q;
        end
        if (i_ctrl.load_gamma) begin
            r_gprod <= $signed({1'b0, i_discount}) * i_best_q;
        end
        if (i_ctrl.load_delta) begin
            r_delta <= n_delta;
        end
        if (i_ctrl.load_alpha) begin
            r_aprod <= $signed({1'b0, i_learn_rate}) * r_delta;
        end
    end

endmodule

`default_nettype wire

// File: rtl/grid_q_learning_update_core.sv
// Top level of the grid Q-learning update core: sequencer, APB registers,
// argmax over the next cell. Uses gql_pkg, gql_move, gql_qmem, gql_update.
`default_nettype none

// One agent step per beat. A beat is taken when start is high and busy is
// low; its result appears on the o_ ports, marked by o_valid for exactly one
// cycle, and the receiver cannot hold it off. busy drops again in the o_valid
// cycle, so a new step can be started there. The sequencer works around the
// Q table, a memory with two read ports and one write port: RD01 and RD23
// read the four Q values of the next cell, RDOLD reads the old Q(s,a), then
// GMUL (gamma multiply), DELTA (TD error), AMUL (alpha multiply) and DONE
// (saturating write-back, skipped in greedy mode) follow in that order. The
// write lands before the next step can read, so no forwarding is needed.
// After reset the block clears the table, one entry per cycle (all
// GRID_W*GRID_H*4 entries, 16384 with the default grid) with busy high;
// register writes are taken throughout.
// Registers sit at byte addresses 0 (learn_rate), 4 (discount), 8 (goal_x)
// and 12 (goal_y) and should be written only while the core is idle.
module grid_q_learning_update_core import gql_pkg::*; #(
    parameter int GRID_W      = 64,
    parameter int GRID_H      = 64,
    parameter int Q_FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               start,
    output logic                    busy,
    input  wire logic [COORD_W-1:0] i_pos_x,
    input  wire logic [COORD_W-1:0] i_pos_y,
    input  wire logic [1:0]         i_action,
    input  wire logic               i_target_blocked,
    input  wire logic               i_mode,

    output logic                    o_valid,
    output logic [COORD_W-1:0]      o_next_x,
    output logic [COORD_W-1:0]      o_next_y,
    output logic signed [7:0]       o_step_reward,
    output logic                    o_reached_goal,
    output logic signed [Q_W-1:0]   o_updated_q,
    output logic [1:0]              o_best_next_action,
    output logic signed [Q_W-1:0]   o_best_next_q,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    // coordinates must hold both the port range and the grid range
    localparam int CX_W    = ($clog2(GRID_W) > COORD_W) ? $clog2(GRID_W) : COORD_W;
    localparam int CY_W    = ($clog2(GRID_H) > COORD_W) ? $clog2(GRID_H) : COORD_W;
    localparam int CELL_W  = $clog2(GRID_W * GRID_H);
    localparam int ADDR_W  = CELL_W + 2;
    localparam int Q_DEPTH = GRID_W * GRID_H * 4;

    // ---------------- configuration registers ----------------
    logic [COEF_W-1:0]  r_learn_rate;
    logic [COEF_W-1:0]  r_discount;
    logic [COORD_W-1:0] r_goal_x;
    logic [COORD_W-1:0] r_goal_y;
    logic               cfg_we;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate <= LEARN_RATE_RST;
            r_discount   <= DISCOUNT_RST;
            r_goal_x     <= GOAL_RST;
            r_goal_y     <= GOAL_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_LEARN_RATE: r_learn_rate <= pwdata[COEF_W-1:0];
                REG_DISCOUNT:   r_discount   <= pwdata[COEF_W-1:0];
                REG_GOAL_X:     r_goal_x     <= pwdata[COORD_W-1:0];
                REG_GOAL_Y:     r_goal_y     <= pwdata[COORD_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LEARN_RATE: prdata = 32'(r_learn_rate);
            REG_DISCOUNT:   prdata = 32'(r_discount);
            REG_GOAL_X:     prdata = 32'(r_goal_x);
            REG_GOAL_Y:     prdata = 32'(r_goal_y);
        endcase
    end

    // ---------------- move decode at the input ----------------
    logic [CX_W-1:0]   mv_nx;
    logic [CY_W-1:0]   mv_ny;
    logic [CELL_W-1:0] mv_cell_cur;
    logic [CELL_W-1:0] mv_cell_next;
    t_move_flags       mv_flags;

    gql_move #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H),
        .CX_W   (CX_W),
        .CY_W   (CY_W),
        .CELL_W (CELL_W)
    ) u_move (
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_action         (i_action),
        .i_target_blocked (i_target_blocked),
        .i_goal_x         (r_goal_x),
        .i_goal_y         (r_goal_y),
        .o_nx             (mv_nx),
        .o_ny             (mv_ny),
        .o_cell_cur       (mv_cell_cur),
        .o_cell_next      (mv_cell_next),
        .o_flags          (mv_flags)
    );

    // ---------------- sequencer ----------------
    t_state r_state;
    t_state n_state;
    logic   accept;

    logic [ADDR_W-1:0] r_clr_addr;
    logic              clr_last;

    // per-step registers, held until the next accepted beat
    logic [CELL_W-1:0]  r_cell_cur;
    logic [CELL_W-1:0]  r_cell_next;
    logic [1:0]         r_act;
    logic               r_greedy;
    logic [COORD_W-1:0] r_next_x;
    logic [COORD_W-1:0] r_next_y;
    t_move_flags        r_flags;

    assign accept   = start && !busy;
    assign clr_last = (r_clr_addr == ADDR_W'(Q_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (start)    n_state = ST_RD01;
            ST_RD01:  n_state = ST_RD23;
            ST_RD23:  n_state = ST_RDOLD;
            ST_RDOLD: n_state = ST_GMUL;
            ST_GMUL:  n_state = ST_DELTA;
            ST_DELTA: n_state = ST_AMUL;
            ST_AMUL:  n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // memory and datapath controls
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [Q_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0] mem_raddr_a;
    logic [ADDR_W-1:0] mem_raddr_b;
    logic [Q_W-1:0]    mem_rdata_a;
    logic [Q_W-1:0]    mem_rdata_b;
    t_upd_ctrl         upd_ctrl;
    logic signed [Q_W-1:0] upd_new_q;

    always_comb begin
        busy        = 1'b1;
        mem_we      = 1'b0;
        mem_waddr   = {r_cell_cur, r_act};
        mem_wdata   = upd_new_q;
        mem_raddr_a = {r_cell_cur, r_act};
        mem_raddr_b = {r_cell_cur, r_act};
        upd_ctrl    = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_RD01: begin
                mem_raddr_a = {r_cell_next, ACT_RIGHT};
                mem_raddr_b = {r_cell_next, ACT_LEFT};
            end
            ST_RD23: begin
                mem_raddr_a = {r_cell_next, ACT_DOWN};
                mem_raddr_b = {r_cell_next, ACT_UP};
            end
            ST_RDOLD: ;
            ST_GMUL: begin
                upd_ctrl.load_old   = 1'b1;
                upd_ctrl.load_gamma = 1'b1;
            end
            ST_DELTA: upd_ctrl.load_delta = 1'b1;
            ST_AMUL:  upd_ctrl.load_alpha = 1'b1;
            ST_DONE:  mem_we = !r_greedy;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell_cur  <= mv_cell_cur;
            r_cell_next <= mv_cell_next;
            r_act       <= i_action;
            r_greedy    <= i_mode;
            r_next_x    <= mv_nx[COORD_W-1:0];
            r_next_y    <= mv_ny[COORD_W-1:0];
            r_flags     <= mv_flags;
        end
    end

    // ---------------- Q table ----------------
    gql_qmem #(
        .DEPTH  (Q_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_qmem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    // ---------------- argmax over the next cell ----------------
    // pairwise tree with strict compares keeps the lowest index on ties
    logic signed [Q_W-1:0] q_a;
    logic signed [Q_W-1:0] q_b;
    logic                  pair_hi;
    logic signed [Q_W-1:0] pair_q;
    logic signed [Q_W-1:0] r_pair_q;
    logic                  r_pair_hi;
    logic signed [Q_W-1:0] r_best_q;
    logic [1:0]            r_best_a;

    assign q_a     = $signed(mem_rdata_a);
    assign q_b     = $signed(mem_rdata_b);
    assign pair_hi = q_b > q_a;
    assign pair_q  = pair_hi ? q_b : q_a;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD23) begin
            r_pair_q  <= pair_q;
            r_pair_hi <= pair_hi;
        end
        if (r_state == ST_RDOLD) begin
            if (pair_q > r_pair_q) begin
                r_best_q <= pair_q;
                r_best_a <= {1'b1, pair_hi};
            end else begin
                r_best_q <= r_pair_q;
                r_best_a <= {1'b0, r_pair_hi};
            end
        end
    end

    // ---------------- update datapath ----------------
    gql_update #(
        .Q_FRAC_BITS (Q_FRAC_BITS)
    ) u_update (
        .i_clk        (i_clk),
        .i_ctrl       (upd_ctrl),
        .i_learn_rate (r_learn_rate),
        .i_discount   (r_discount),
        .i_reward     (r_flags.reward),
        .i_greedy     (r_greedy),
        .i_best_q     (r_best_q),
        .i_old_q      ($signed(mem_rdata_a)),
        .o_new_q      (upd_new_q)
    );

    // ---------------- result beat ----------------
    logic                  r_valid;
    logic signed [Q_W-1:0] r_updated_q;
    logic signed [Q_W-1:0] r_out_best_q;
    logic [1:0]            r_out_best_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            r_updated_q  <= upd_new_q;
            r_out_best_q <= r_best_q;
            r_out_best_a <= r_best_a;
        end
    end

    assign o_valid            = r_valid;
    assign o_next_x           = r_next_x;
    assign o_next_y           = r_next_y;
    assign o_step_reward      = r_flags.reward;
    assign o_reached_goal     = r_flags.goal;
    assign o_updated_q        = r_updated_q;
    assign o_best_next_action = r_out_best_a;
    assign o_best_next_q      = r_out_best_q;

    // ---------------- assertions ----------------
    a_step_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##8 o_valid)
        else $error("result beat missing 8 cycles after accept");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_DONE))
        else $error("result strobe without a finished step");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("core busy during result beat");

    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state == ST_CLEAR))
            |-> $past(r_clr_addr) == ADDR_W'(Q_DEPTH - 1))
        else $error("clearing pass ended early");

endmodule

`default_nettype wire
